[hdl/dq_pkg.sv]
// Shared constants, command codes, result type and ring helpers for the deque core.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    localparam int DEPTH   = 64;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int CMD_W   = 3;
    localparam int OCC_W   = 7;
    localparam int IN_DATA_W  = WORD_W;
    localparam int OUT_DATA_W = ((3 * WORD_W + OCC_W + 3 + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_QUERY      = CMD_W'(4);

    localparam logic [WORD_W-1:0] NO_WORD    = '1;
    localparam logic [CNT_W-1:0]  COUNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(DEPTH - 1);

    typedef struct packed {
        logic [WORD_W-1:0] popped_word;
        logic              underflow;
        logic              overflow;
        logic [WORD_W-1:0] front_word;
        logic [WORD_W-1:0] back_word;
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
    } res_t;

    // Step toward the front of the ring
    function automatic logic [PTR_W-1:0] ptr_up(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    // Step toward the back of the ring
    function automatic logic [PTR_W-1:0] ptr_down(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == '0) ? PTR_LAST : p - PTR_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/double_ended_queue_core.sv]
// Top level of the deque core: stream ports, ring memory, controller and result register.
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of 32-bit words held in a 64-entry ring.
// Input stream: s_tuser carries the command (push front, push back, pop front,
// pop back, query; unused codes act as query), s_tdata the word to push.
// Output stream: one transfer per input item with the popped word, the
// underflow and overflow flags, the front and back words after the step, the
// occupancy and an empty flag. -1 stands for "no word".
// Timing: an input transfer is taken in the idle cycle; the next cycle the
// ring read (needed only to refill an end after a pop) returns, and the result
// is loaded into the output register once that register is free. No new item
// is taken until the result of the last one has been loaded, as the ring
// memory read lies between the pointer update and the result.
// s_tready is high while the controller is idle, also while a finished result
// still sits in the output register. When the receiver stalls, the controller
// holds its next result and the ring read data until the register frees up.
// Reset clears pointers, count and valid state; the ring contents are left
// as they are and only written entries are ever read.
module double_ended_queue_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [dq_pkg::IN_DATA_W-1:0]      s_tdata,   // [31:0] value
    input  wire logic [dq_pkg::CMD_W-1:0]          s_tuser,   // [2:0] command
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] popped_word, [32] underflow, [33] overflow, [65:34] front_word,
    // [97:66] back_word, [104:98] occupancy, [105] is_empty, rest zero
    output logic      [dq_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int PAYLOAD_W = 3 * dq_pkg::WORD_W + dq_pkg::OCC_W + 3;

    logic                           res_valid;
    dq_pkg::res_t                   res;
    logic                           out_free;

    logic                           ram_we;
    logic [dq_pkg::PTR_W-1:0]       ram_waddr;
    logic [dq_pkg::WORD_W-1:0]      ram_wdata;
    logic                           ram_re;
    logic [dq_pkg::PTR_W-1:0]       ram_raddr;
    logic [dq_pkg::WORD_W-1:0]      ram_rdata;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [PAYLOAD_W-1:0]           m_payload_reg;

    // output register is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    dq_ram #(
        .WIDTH (dq_pkg::WORD_W),
        .DEPTH (dq_pkg::DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .command   (s_tuser),
        .value     (s_tdata[dq_pkg::WORD_W-1:0]),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && out_free)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload packed lowest field first
    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            m_payload_reg <= {res.is_empty, res.occupancy, res.back_word,
                              res.front_word, res.overflow, res.underflow,
                              res.popped_word};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = dq_pkg::OUT_DATA_W'(m_payload_reg);

endmodule

`default_nettype wire

[hdl/dq_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/dq_ctrl.sv]
// Deque controller: pointers, count, cached end words and the ring access sequencer.
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dq_pkg::CMD_W-1:0]      command,
    input  wire logic [dq_pkg::WORD_W-1:0]     value,
    input  wire logic                          out_free,
    output logic                               res_valid,
    output dq_pkg::res_t                       res,
    output logic                               ram_we,
    output logic      [dq_pkg::PTR_W-1:0]      ram_waddr,
    output logic      [dq_pkg::WORD_W-1:0]     ram_wdata,
    output logic                               ram_re,
    output logic      [dq_pkg::PTR_W-1:0]      ram_raddr,
    input  wire logic [dq_pkg::WORD_W-1:0]     ram_rdata
);

    typedef enum logic {ST_IDLE, ST_RESULT} state_t;

    state_t                      state_reg, state_next;
    logic [dq_pkg::PTR_W-1:0]    front_ptr_reg, front_ptr_next;
    logic [dq_pkg::PTR_W-1:0]    back_ptr_reg, back_ptr_next;
    logic [dq_pkg::CNT_W-1:0]    count_reg, count_next;

    // cached end words, and what the pending step produced
    logic [dq_pkg::WORD_W-1:0]   front_word_reg, front_word_next;
    logic [dq_pkg::WORD_W-1:0]   back_word_reg, back_word_next;
    logic [dq_pkg::WORD_W-1:0]   popped_reg, popped_next;
    logic                        under_reg, under_next;
    logic                        over_reg, over_next;
    logic                        fix_front_reg, fix_front_next;
    logic                        fix_back_reg, fix_back_next;

    logic                        accept;
    logic                        empty;
    logic                        full;
    logic [dq_pkg::CNT_W-1:0]    count_dec;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == dq_pkg::COUNT_FULL);
    assign count_dec = count_reg - dq_pkg::CNT_W'(1);
    assign res_valid = (state_reg == ST_RESULT);

    always_comb
    begin
        state_next      = state_reg;
        front_ptr_next  = front_ptr_reg;
        back_ptr_next   = back_ptr_reg;
        count_next      = count_reg;
        front_word_next = front_word_reg;
        back_word_next  = back_word_reg;
        popped_next     = popped_reg;
        under_next      = under_reg;
        over_next       = over_reg;
        fix_front_next  = fix_front_reg;
        fix_back_next   = fix_back_reg;
        ram_we          = 1'b0;
        ram_waddr       = front_ptr_reg;
        ram_wdata       = value;
        ram_re          = 1'b0;
        ram_raddr       = front_ptr_reg;

        if (accept)
        begin
            state_next     = ST_RESULT;
            popped_next    = dq_pkg::NO_WORD;
            under_next     = 1'b0;
            over_next      = 1'b0;
            fix_front_next = 1'b0;
            fix_back_next  = 1'b0;
            case (command)
                dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        over_next = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + dq_pkg::CNT_W'(1);
                        if (empty)
                        begin
                            // first word: both ends meet at the front pointer
                            back_ptr_next   = front_ptr_reg;
                            ram_waddr       = front_ptr_reg;
                            front_word_next = value;
                            back_word_next  = value;
                        end
                        else if (command == dq_pkg::CMD_PUSH_FRONT)
                        begin
                            front_ptr_next  = dq_pkg::ptr_up(front_ptr_reg);
                            ram_waddr       = front_ptr_next;
                            front_word_next = value;
                        end
                        else
                        begin
                            back_ptr_next  = dq_pkg::ptr_down(back_ptr_reg);
                            ram_waddr      = back_ptr_next;
                            back_word_next = value;
                        end
                    end
                end
                dq_pkg::CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        under_next = 1'b1;
                    end
                    else
                    begin
                        popped_next    = front_word_reg;
                        front_ptr_next = dq_pkg::ptr_down(front_ptr_reg);
                        count_next     = count_dec;
                        ram_re         = (count_dec != '0);
                        ram_raddr      = front_ptr_next;
                        fix_front_next = (count_dec != '0);
                    end
                end
                dq_pkg::CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        under_next = 1'b1;
                    end
                    else
                    begin
                        popped_next   = back_word_reg;
                        back_ptr_next = dq_pkg::ptr_up(back_ptr_reg);
                        count_next    = count_dec;
                        ram_re        = (count_dec != '0);
                        ram_raddr     = back_ptr_next;
                        fix_back_next = (count_dec != '0);
                    end
                end
                default:
                begin
                    // query and unused codes change nothing
                end
            endcase
        end
        else if ((state_reg == ST_RESULT) && out_free)
        begin
            state_next = ST_IDLE;
            if (fix_front_reg)
            begin
                front_word_next = ram_rdata;
            end
            if (fix_back_reg)
            begin
                back_word_next = ram_rdata;
            end
            fix_front_next = 1'b0;
            fix_back_next  = 1'b0;
        end
    end

    // result view: the refilled end comes straight from the ram read port
    always_comb
    begin
        res.popped_word = popped_reg;
        res.underflow   = under_reg;
        res.overflow    = over_reg;
        res.front_word  = empty ? dq_pkg::NO_WORD
                                : (fix_front_reg ? ram_rdata : front_word_reg);
        res.back_word   = empty ? dq_pkg::NO_WORD
                                : (fix_back_reg ? ram_rdata : back_word_reg);
        res.occupancy   = dq_pkg::OCC_W'(count_reg);
        res.is_empty    = empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_ptr_reg <= '0;
            back_ptr_reg  <= '0;
            count_reg     <= '0;
            fix_front_reg <= 1'b0;
            fix_back_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_ptr_reg <= front_ptr_next;
            back_ptr_reg  <= back_ptr_next;
            count_reg     <= count_next;
            fix_front_reg <= fix_front_next;
            fix_back_reg  <= fix_back_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_word_reg <= front_word_next;
        back_word_reg  <= back_word_next;
        popped_reg     <= popped_next;
        under_reg      <= under_next;
        over_reg       <= over_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dq_pkg::COUNT_FULL)
        else $error("deque count beyond ring depth");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("new item taken while previous result pending");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.underflow && res.overflow))
        else $error("underflow and overflow raised together");

    a_first_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && empty && (command == dq_pkg::CMD_PUSH_FRONT ||
                             command == dq_pkg::CMD_PUSH_BACK))
        |=> (count_reg == dq_pkg::CNT_W'(1)) && (front_ptr_reg == back_ptr_reg))
        else $error("push into empty ring left ends apart");

    a_single_refill: assert property (@(posedge clk) disable iff (!rst_n)
        !(fix_front_reg && fix_back_reg))
        else $error("both ends waiting on one ram read");
`endif

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the deque core: directed and random command streams.
`timescale 1ns / 1ps

// Drives command/word transfers into double_ended_queue_core and checks every
// result transfer against a shadow deque kept in the testbench.
// Directed tests cover the empty queue, pushes and pops at both ends with
// extreme words, and the unused command codes. Random traffic runs in
// fill, drain and mixed phases, so the ring reaches full and overflows, and
// drains to empty and underflows. These phases run under three back-pressure
// patterns: sender gaps with a slow receiver, the reverse, then none.
module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_LIMIT = 10;
    localparam int VIEW_SLOTS   = 16;

    // One result as the shadow deque sees it
    typedef struct packed {
        logic [dq_pkg::WORD_W-1:0] popped;
        logic                      under;
        logic                      over;
        logic [dq_pkg::WORD_W-1:0] front;
        logic [dq_pkg::WORD_W-1:0] back;
        logic [dq_pkg::OCC_W-1:0]  occ;
        logic                      empty;
        logic [5:0]                pad;
    } deque_view_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [dq_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic [dq_pkg::CMD_W-1:0]      s_tuser  = dq_pkg::CMD_QUERY;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [dq_pkg::OUT_DATA_W-1:0] m_tdata;

    // Shadow deque
    logic [dq_pkg::WORD_W-1:0] shadow_words [dq_pkg::DEPTH];
    int                shadow_front = 0;
    int                shadow_back  = 0;
    int                shadow_count = 0;

    // Expected results in flight, kept as a small ring
    deque_view_t       expected_views [VIEW_SLOTS];
    int                views_written = 0;
    int                views_read    = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int error_count    = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int overflows_seen = 0;
    int underflows_seen = 0;
    int peak_count     = 0;

    double_ended_queue_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Receiver back-pressure, changed at the falling edge
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Works out the result of one accepted command and queues it
    task automatic step_shadow_deque(input logic [dq_pkg::CMD_W-1:0] cmd,
                                     input logic [dq_pkg::WORD_W-1:0] word);
        deque_view_t v;
        v = '0;
        v.popped = dq_pkg::NO_WORD;
        case (cmd)
            dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK:
            begin
                if (shadow_count >= dq_pkg::DEPTH)
                    v.over = 1'b1;
                else
                begin
                    if (shadow_count == 0)
                        shadow_back = shadow_front;
                    else if (cmd == dq_pkg::CMD_PUSH_FRONT)
                        shadow_front = (shadow_front + 1) % dq_pkg::DEPTH;
                    else
                        shadow_back = (shadow_back + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
                    if (cmd == dq_pkg::CMD_PUSH_FRONT)
                        shadow_words[shadow_front] = word;
                    else
                        shadow_words[shadow_back] = word;
                    shadow_count++;
                end
            end
            dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK:
            begin
                if (shadow_count == 0)
                    v.under = 1'b1;
                else if (cmd == dq_pkg::CMD_POP_FRONT)
                begin
                    v.popped = shadow_words[shadow_front];
                    shadow_front = (shadow_front + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
                    shadow_count--;
                end
                else
                begin
                    v.popped = shadow_words[shadow_back];
                    shadow_back = (shadow_back + 1) % dq_pkg::DEPTH;
                    shadow_count--;
                end
            end
            default: ; // query and unused codes change nothing
        endcase
        v.front = (shadow_count != 0) ? shadow_words[shadow_front] : dq_pkg::NO_WORD;
        v.back  = (shadow_count != 0) ? shadow_words[shadow_back]  : dq_pkg::NO_WORD;
        v.occ   = dq_pkg::OCC_W'(shadow_count);
        v.empty = (shadow_count == 0);
        if (v.over)
            overflows_seen++;
        if (v.under)
            underflows_seen++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        expected_views[views_written % VIEW_SLOTS] = v;
        views_written++;
    endtask

    // Sends one command; returns once the transfer has been accepted.
    // s_tvalid stays high into the next call so back-to-back items need no gap.
    task automatic send_command(input logic [dq_pkg::CMD_W-1:0] cmd,
                                input logic [dq_pkg::WORD_W-1:0] word);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        step_shadow_deque(cmd, word);
    endtask

    // Result checker, sampled at the rising edge
    always @(posedge clk)
    begin
        deque_view_t got;
        deque_view_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            // m_tdata layout from bit 0 up: popped, underflow, overflow,
            // front, back, occupancy, empty, zero padding
            got.popped = m_tdata[31:0];
            got.under  = m_tdata[32];
            got.over   = m_tdata[33];
            got.front  = m_tdata[65:34];
            got.back   = m_tdata[97:66];
            got.occ    = m_tdata[104:98];
            got.empty  = m_tdata[105];
            got.pad    = m_tdata[111:106];
            results_seen++;
            if (views_read == views_written)
                note_failure($sformatf("result transfer with none expected: %h", m_tdata));
            else
            begin
                want = expected_views[views_read % VIEW_SLOTS];
                views_read++;
                if (got.popped !== want.popped)
                    note_failure($sformatf("popped_word exp %h got %h", want.popped, got.popped));
                if (got.under !== want.under)
                    note_failure($sformatf("underflow exp %b got %b", want.under, got.under));
                if (got.over !== want.over)
                    note_failure($sformatf("overflow exp %b got %b", want.over, got.over));
                if (got.front !== want.front)
                    note_failure($sformatf("front_word exp %h got %h", want.front, got.front));
                if (got.back !== want.back)
                    note_failure($sformatf("back_word exp %h got %h", want.back, got.back));
                if (got.occ !== want.occ)
                    note_failure($sformatf("occupancy exp %0d got %0d", want.occ, got.occ));
                if (got.empty !== want.empty)
                    note_failure($sformatf("is_empty exp %b got %b", want.empty, got.empty));
                if (got.pad !== want.pad)
                    note_failure($sformatf("padding exp %h got %h", want.pad, got.pad));
            end
        end
    end

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    // Empty queue: query, pops at both ends, an unused code
    task automatic test_empty_queue();
        send_command(dq_pkg::CMD_QUERY, 32'h1234_5678);
        send_command(dq_pkg::CMD_POP_FRONT, '0);
        send_command(dq_pkg::CMD_POP_BACK, '1);
        send_command(dq_pkg::CMD_W'(5), 32'h8000_0000);
    endtask

    // Both ends with extreme words, draining to empty and refilling
    task automatic test_both_ends();
        send_command(dq_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        send_command(dq_pkg::CMD_PUSH_BACK, 32'h8000_0000);
        send_command(dq_pkg::CMD_PUSH_FRONT, 32'h0000_0000);
        send_command(dq_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF);
        send_command(dq_pkg::CMD_QUERY, 32'hDEAD_BEEF);
        send_command(dq_pkg::CMD_POP_FRONT, 32'h5555_5555);
        send_command(dq_pkg::CMD_POP_BACK, 32'hAAAA_AAAA);
        send_command(dq_pkg::CMD_POP_BACK, '0);
        send_command(dq_pkg::CMD_POP_FRONT, '0);
        send_command(dq_pkg::CMD_POP_FRONT, '0);
        // pointers were left where the last pop put them
        send_command(dq_pkg::CMD_PUSH_BACK, 32'h0F0F_0F0F);
        send_command(dq_pkg::CMD_POP_FRONT, '0);
        send_command(dq_pkg::CMD_PUSH_FRONT, 32'hF0F0_F0F0);
    endtask

    // Unused command codes behave as a query, also with data present
    task automatic test_unused_commands();
        send_command(dq_pkg::CMD_W'(5), 32'hFFFF_FFFF);
        send_command(dq_pkg::CMD_W'(6), 32'h0000_0001);
        send_command(dq_pkg::CMD_W'(7), 32'h8000_0000);
        send_command(dq_pkg::CMD_POP_BACK, '0);
    endtask

    // Random commands; push_pct steers the occupancy up or down
    task automatic random_phase(input int count, input int push_pct);
        int                        r;
        logic [dq_pkg::CMD_W-1:0]  cmd;
        logic [dq_pkg::WORD_W-1:0] word;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < push_pct)
                cmd = $urandom_range(1) ? dq_pkg::CMD_PUSH_BACK : dq_pkg::CMD_PUSH_FRONT;
            else if (r < 90)
                cmd = $urandom_range(1) ? dq_pkg::CMD_POP_BACK : dq_pkg::CMD_POP_FRONT;
            else
                cmd = dq_pkg::CMD_W'($urandom_range(7, 4));
            case ($urandom_range(15))
                0:       word = 32'h7FFF_FFFF;
                1:       word = 32'h8000_0000;
                2:       word = '0;
                3:       word = '1;
                default: word = $urandom;
            endcase
            send_command(cmd, word);
        end
    endtask

    // Fill past full, drain past empty, then a balanced mix
    task automatic test_random_traffic();
        random_phase(110, 80);
        random_phase(110, 10);
        random_phase(100, 45);
    endtask

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        set_idling(33, 60);
        test_empty_queue();
        test_both_ends();
        test_unused_commands();
        test_random_traffic();

        set_idling(60, 33);
        test_random_traffic();

        set_idling(0, 0);
        test_random_traffic();

        @(negedge clk);
        s_tvalid <= 1'b0;

        while (views_read != views_written)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands sent, %0d results checked, %0d mismatches",
                 items_sent, results_seen, error_count);
        $display("peak occupancy %0d of %0d, %0d dropped pushes, %0d pops on empty",
                 peak_count, dq_pkg::DEPTH, overflows_seen, underflows_seen);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
